// ===== rtl/cwsg_pkg.sv =====
// Shared types and constants for the circle window span generator.
// No dependencies; imported by every module of the block.
package cwsg_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_CENTER_X = 2'd0;
	localparam logic [1:0] CFG_CENTER_Y = 2'd1;
	localparam logic [1:0] CFG_RADIUS   = 2'd2;

	localparam logic [7:0] CENTER_X_RST = 8'd128;
	localparam logic [7:0] CENTER_Y_RST = 8'd112;
	localparam logic [7:0] RADIUS_RST   = 8'd0;

	localparam logic [7:0] EDGE_MAX = 8'hFF;

	// bit-pair square root: 8 steps, two per stage
	localparam logic [15:0] ROOT_PROBE  = 16'h4000;
	localparam int          SQRT_STAGES = 4;

	typedef struct packed {
		logic valid;
		logic hit;
	} cwsg_ctl_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] root;
	} cwsg_sq_t;

endpackage

// ===== rtl/cwsg_sqrt_pipe.sv =====
// Pipelined 16-bit integer square root, bit-pair method, two steps per stage.
// Depends on cwsg_pkg for the control struct and the remainder/root pair.
module cwsg_sqrt_pipe import cwsg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cwsg_ctl_t  in_ctl,
	input  logic [15:0] in_rem,
	output cwsg_ctl_t  out_ctl,
	output logic [7:0] out_root,
	output logic       out_pend
);

	function automatic cwsg_sq_t sq_step(cwsg_sq_t a, logic [15:0] probe);
		logic [16:0] trial;
		cwsg_sq_t    r;
		trial = {1'b0, a.root} + {1'b0, probe};
		if ({1'b0, a.rem} >= trial) begin
			r.rem  = a.rem - a.root - probe;
			r.root = (a.root >> 1) + probe;
		end else begin
			r.rem  = a.rem;
			r.root = a.root >> 1;
		end
		return r;
	endfunction

	cwsg_ctl_t ctl_s [0:SQRT_STAGES];
	cwsg_sq_t  sq_s  [0:SQRT_STAGES];
	logic [SQRT_STAGES-1:0] stage_vld;

	assign ctl_s[0]     = in_ctl;
	assign sq_s[0].rem  = in_rem;
	assign sq_s[0].root = 16'd0;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [15:0] PROBE_A = ROOT_PROBE >> (4 * k);
		localparam logic [15:0] PROBE_B = ROOT_PROBE >> (4 * k + 2);

		cwsg_sq_t mid;
		cwsg_sq_t nxt;

		always_comb begin
			mid = sq_step(sq_s[k], PROBE_A);
			nxt = sq_step(mid, PROBE_B);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_s[k+1] <= nxt;
		end

		assign stage_vld[k] = ctl_s[k+1].valid;
	end

	assign out_ctl  = ctl_s[SQRT_STAGES];
	// root of a 16-bit value fits in 8 bits
	assign out_root = sq_s[SQRT_STAGES].root[7:0];
	// any request still held in one of the root stages
	assign out_pend = |stage_vld;

endmodule

// ===== rtl/circle_window_span_generator_core.sv =====
// Circle window span generator, top level.
// Depends on cwsg_pkg and cwsg_sqrt_pipe.
//
// Usage:
//   Request channel: drive line and pulse start; a request is taken at each
//   rising edge with start high and busy low. busy stays low, so one line
//   can be issued every cycle.
//   Result channel: done is high for one cycle with left_edge, right_edge
//   and inside_res. The receiver cannot stall; results come in request order.
//   From the accepting edge to the result a request passes through distance,
//   squaring, compare/subtract, four square-root stages (two bit-pair steps
//   each) and the edge/clamp output register.
//   Throughput is one line per cycle, set by the fully pipelined root.
//   Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are both high. cfg_ready is high only while no request is in flight.
//   Index 0 center_x, 1 center_y, 2 radius; other indexes are ignored.
//   Reset clears the pipeline and loads center (128,112) and radius 0.
module circle_window_span_generator_core import cwsg_pkg::*; #(
	parameter int LINES = 224
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] line,
	output logic       done,
	output logic [7:0] left_edge,
	output logic [7:0] right_edge,
	output logic       inside_res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam logic [8:0] LINES_W = 9'(LINES);

	logic [7:0] center_x_q;
	logic [7:0] center_y_q;
	logic [7:0] radius_q;

	logic       accept;
	logic       valid_s1, valid_s2;
	logic       onscr_s1, onscr_s2;
	logic [7:0] dist_s1;
	logic [15:0] dy2_s2, r2_s2;
	cwsg_ctl_t  ctl_s3;
	logic [15:0] rem_s3;
	cwsg_ctl_t  root_ctl;
	logic [7:0] root;
	logic       sqrt_pend;
	logic       in_flight;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign in_flight = valid_s1 | valid_s2 | ctl_s3.valid | sqrt_pend;
	assign cfg_ready = ~in_flight & ~start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			radius_q   <= RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_RADIUS:   radius_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// control valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_s3   <= '0;
		end else begin
			valid_s1     <= accept;
			valid_s2     <= valid_s1;
			ctl_s3.valid <= valid_s2;
			ctl_s3.hit   <= onscr_s2 && (dy2_s2 < r2_s2);
		end
	end

	always_ff @(posedge clk) begin
		dist_s1  <= (line >= center_y_q) ? (line - center_y_q) : (center_y_q - line);
		onscr_s1 <= {1'b0, line} < LINES_W;
		dy2_s2   <= {8'd0, dist_s1} * {8'd0, dist_s1};
		r2_s2    <= {8'd0, radius_q} * {8'd0, radius_q};
		onscr_s2 <= onscr_s1;
		// outside lines feed zero so the root stays harmless
		rem_s3   <= (dy2_s2 < r2_s2) ? (r2_s2 - dy2_s2) : 16'd0;
	end

	cwsg_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_s3),
		.in_rem   (rem_s3),
		.out_ctl  (root_ctl),
		.out_root (root),
		.out_pend (sqrt_pend)
	);

	logic [8:0] right_sum;
	assign right_sum = {1'b0, center_x_q} + {1'b0, root};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= root_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		inside_res <= root_ctl.hit;
		if (root_ctl.hit) begin
			left_edge  <= (root > center_x_q) ? 8'd0 : (center_x_q - root);
			right_edge <= right_sum[8] ? EDGE_MAX : right_sum[7:0];
		end else begin
			left_edge  <= EDGE_MAX;
			right_edge <= 8'd0;
		end
	end

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && inside_res |-> left_edge <= right_edge)
		else $error("span left edge past right edge");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		done && !inside_res |-> left_edge == EDGE_MAX && right_edge == 8'd0)
		else $error("outside line without empty window");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##8 done)
		else $error("result missing eight cycles after request");

endmodule
